// File: rtl/upd_pkg.sv
// shared types, character constants and decode functions of the url percent decoder
// no dependencies
package upd_pkg;

   localparam int HoldMax    = 5;
   localparam int WorkMax    = HoldMax + 1;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int CntW       = $clog2(WorkMax + 1);

   localparam logic [7:0] CharPct   = 8'h25;
   localparam logic [7:0] CharPlus  = 8'h2b;
   localparam logic [7:0] CharU     = 8'h75;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [3:0] NibAlpha  = 4'd9;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_hex;
      logic [3:0] nib;
   } char_type;

   typedef struct packed {
      char_type c;
      logic     fin;
   } entry_type;

   typedef char_type [WorkMax-1:0] window_type;

   typedef struct packed {
      logic            emit;
      logic [7:0]      data;
      logic [CntW-1:0] consume;
   } decision_type;

   function automatic char_type classify(logic [7:0] b);
      char_type r;
      r.ch     = b;
      r.is_hex = 1'b0;
      r.nib    = b[3:0];
      if (b >= 8'h30 && b <= 8'h39) begin
         r.is_hex = 1'b1;
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r.is_hex = 1'b1;
         r.nib    = b[3:0] + NibAlpha;
      end
      return r;
   endfunction

   // one scan step over the held window: emit one byte or stop for more input
   function automatic decision_type decide(window_type w, logic [CntW-1:0] cnt, logic fin);
      decision_type d;
      logic         bad;
      d.emit    = 1'b1;
      d.data    = CharPct;
      d.consume = CntW'(1);
      bad       = 1'b0;
      for (int i = 2; i < WorkMax; i++) begin
         if (CntW'(i) < cnt && !w[i].is_hex) begin
            bad = 1'b1;
         end
      end
      if (cnt == '0) begin
         d.emit = 1'b0;
      end else if (w[0].ch != CharPct) begin
         d.data = (w[0].ch == CharPlus) ? CharSpace : w[0].ch;
      end else if (cnt < CntW'(2)) begin
         d.emit = fin;
      end else if (w[1].ch == CharU) begin
         if (!bad && cnt == CntW'(WorkMax)) begin
            d.data    = {w[4].nib, w[5].nib};
            d.consume = CntW'(WorkMax);
         end else if (!bad && !fin) begin
            d.emit = 1'b0;
         end
      end else if (w[1].is_hex) begin
         if (cnt < CntW'(3)) begin
            d.emit = fin;
         end else if (w[2].is_hex) begin
            d.data    = {w[1].nib, w[2].nib};
            d.consume = CntW'(3);
         end
      end
      return d;
   endfunction

   function automatic window_type drop(window_type w, logic [CntW-1:0] n);
      window_type r;
      case (n)
         CntW'(1): r = w >> $bits(char_type);
         CntW'(3): r = w >> (3 * $bits(char_type));
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/upd_req_if.sv
// request channel of the url percent decoder: one encoded byte per transfer
// no dependencies
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// File: rtl/upd_rsp_if.sv
// response channel of the url percent decoder: one decoded byte per transfer
// no dependencies
interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       string_done;

   modport source (output valid, output out_byte, output last_of_run, output string_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input string_done,
                 output ready);
endinterface

// File: rtl/upd_front.sv
// front end: takes request transfers, classifies each byte and queues it for the back end
// depends on upd_pkg and upd_req_if
module upd_front
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req,
   output logic      q_valid,
   output entry_type q_entry,
   input  logic      q_pop
);

   entry_type          mem_ff [QueueDepth];
   entry_type          mem_in;
   logic [QPtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPtrW:0]     cnt_ff, cnt_in;
   logic               push, pop;

   assign req.ready = (cnt_ff != (QPtrW+1)'(QueueDepth));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_pop;
   assign q_entry   = mem_ff[rd_ff];

   always_comb begin
      mem_in.c   = classify(req.in_byte);
      mem_in.fin = req.end_of_string;
      wr_in      = push ? wr_ff + QPtrW'(1) : wr_ff;
      rd_in      = pop ? rd_ff + QPtrW'(1) : rd_ff;
      cnt_in     = cnt_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/upd_back.sv
// back end: scans the held window, emits one decoded byte per cycle into the output register while rsp does not stall
// depends on upd_pkg and upd_rsp_if
module upd_back
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_pop,
   upd_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   window_type      win_ff, win_in, win_sh;
   logic [CntW-1:0] cnt_ff, cnt_in, cnt_sh;
   logic            fin_ff, fin_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_data_ff, out_data_in;
   logic            out_last_ff, out_last_in;
   logic            out_done_ff, out_done_in;
   logic            out_free, push;
   decision_type    d0, d1;

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = out_data_ff;
   assign rsp.last_of_run = out_last_ff;
   assign rsp.string_done = out_done_ff;

   always_comb begin
      out_free = !out_valid_ff || rsp.ready;
      d0       = decide(win_ff, cnt_ff, fin_ff);
      win_sh   = drop(win_ff, d0.consume);
      cnt_sh   = cnt_ff - d0.consume;
      // look one step ahead to flag the final result of this byte
      d1       = decide(win_sh, cnt_sh, fin_ff);

      state_in = state_ff;
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      q_pop    = 1'b0;
      push     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            q_pop = 1'b1;
            if (q_valid) begin
               win_in[cnt_ff] = q_entry.c;
               cnt_in         = cnt_ff + CntW'(1);
               fin_in         = q_entry.fin;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!d0.emit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push   = 1'b1;
               win_in = win_sh;
               cnt_in = cnt_sh;
               if (!d1.emit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (out_free) begin
         out_valid_in = push;
         out_data_in  = d0.data;
         out_last_in  = !d1.emit;
         out_done_in  = fin_ff && !d1.emit;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      fin_ff      <= fin_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: rtl/url_percent_decoder.sv
// top level of the url percent decoder: front end, byte queue and scanning back end
// depends on upd_pkg, upd_req_if, upd_rsp_if, upd_front and upd_back
//
// Encoded bytes arrive on req, one per transfer, with end_of_string on the last byte
// of a string. Decoded bytes leave on rsp, one per transfer; last_of_run marks the
// final byte produced by one request byte and string_done the final byte of a string.
// '+' gives a space, '%hh' the byte, '%uhhhh' the low byte, and a '%' whose escape
// fails or is cut short gives a literal '%' with the held bytes scanned again.
// A request byte goes into a four-entry queue; its decoded bytes then pass through the
// scan window and the output register before they are offered on rsp.
// The back end takes a byte from the queue while idle and then scans it, emitting one
// decoded byte per step; it takes no new byte before the held ones need more input.
// A byte that only extends an escape emits nothing.
// When rsp stalls, the output register holds its byte, the back end waits and the
// queue keeps taking request bytes until it is full.
// Reset empties the queue, the window and the output register.
module url_percent_decoder
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req,
   upd_rsp_if.source rsp
);

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   upd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   upd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

// File: tb/sv/tb_url_percent_decoder.sv
// self-checking testbench of the url percent decoder: directed table, then random strings
// depends on upd_pkg, upd_req_if, upd_rsp_if and url_percent_decoder
module tb_url_percent_decoder;
   import upd_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } dec_byte_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
      logic       typed;
      logic [7:0] typed_byte;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } enc_byte_type;

   typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_type;

   localparam int DirRows     = 26;
   localparam int RandomBytes = 350;
   localparam int HoldCycles  = 400;
   localparam int HoldAfter   = 150;

   logic clock;
   logic reset;

   upd_req_if req_if ();
   upd_rsp_if rsp_if ();

   url_percent_decoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // predictor state: bytes held back while an escape is undecided
   logic [7:0]   held_bytes [HoldMax];
   int           held_cnt;
   dec_byte_type step_res [WorkMax];

   dec_byte_type decoded_q [$];
   enc_byte_type enc_q [$];
   dir_row_type  dir_tab [DirRows];

   int bytes_sent;
   int strings_sent;
   int bytes_checked;
   int strings_done;
   int err_cnt;
   int burst_left;

   initial clock = 1'b0;

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("timeout with %0d decoded bytes outstanding", decoded_q.size());
      $display("tb_url_percent_decoder failed");
      $finish;
   end

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // decodes one encoded byte against the held bytes, fills step_res, returns the count
   function automatic int decode_step(logic [7:0] b, logic fin);
      logic [7:0] win [WorkMax];
      int         n;
      int         pos;
      int         k;
      int         avail;
      int         lim;
      int         i;
      bit         bad;
      bit         stop;
      logic [7:0] c;
      logic [7:0] c1;
      logic [7:0] res;
      n    = held_cnt;
      pos  = 0;
      k    = 0;
      stop = 1'b0;
      for (i = 0; i < n; i++) win[i] = held_bytes[i];
      win[n] = b;
      n++;
      while (pos < n && k < WorkMax && !stop) begin
         avail = n - pos;
         c     = win[pos];
         res   = CharPct;
         if (c != CharPct) begin
            res = (c == CharPlus) ? CharSpace : c;
            pos++;
         end else if (avail < 2) begin
            if (!fin) stop = 1'b1;
            else pos++;
         end else begin
            c1 = win[pos+1];
            if (c1 == CharU) begin
               bad = 1'b0;
               lim = (avail < WorkMax) ? avail : WorkMax;
               for (i = 2; i < lim; i++)
                  if (hex_digit(win[pos+i]) < 0) bad = 1'b1;
               if (!bad && lim == WorkMax) begin
                  res = 8'(hex_digit(win[pos+4]) * 16 + hex_digit(win[pos+5]));
                  pos += WorkMax;
               end else if (!bad && !fin) begin
                  stop = 1'b1;
               end else begin
                  pos++;
               end
            end else if (hex_digit(c1) >= 0) begin
               if (avail < 3) begin
                  if (!fin) stop = 1'b1;
                  else pos++;
               end else if (hex_digit(win[pos+2]) >= 0) begin
                  res = 8'(hex_digit(c1) * 16 + hex_digit(win[pos+2]));
                  pos += 3;
               end else begin
                  pos++;
               end
            end else begin
               pos++;
            end
         end
         if (!stop) begin
            step_res[k] = '{res, 1'b0, 1'b0};
            k++;
         end
      end
      held_cnt = n - pos;
      for (i = 0; i < held_cnt; i++) held_bytes[i] = win[pos+i];
      if (k > 0) begin
         step_res[k-1].last_of_run = 1'b1;
         step_res[k-1].string_done = fin;
      end
      return k;
   endfunction

   task automatic send_byte(logic [7:0] b, logic eos, logic typed, logic [7:0] typed_byte);
      int k;
      int gap;
      int i;
      req_if.valid         <= 1'b1;
      req_if.in_byte       <= b;
      req_if.end_of_string <= eos;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      bytes_sent++;
      if (eos) strings_sent++;
      k = decode_step(b, eos);
      if (typed) decoded_q.push_back('{typed_byte, 1'b1, eos});
      else for (i = 0; i < k; i++) decoded_q.push_back(step_res[i]);
      // burst over: drop valid for a gap before the next burst
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 12);
      end
   endtask

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
      return b;
   endfunction

   // well-formed escapes with random content, some broken ones and noise
   function automatic void build_string();
      logic [7:0] s [$];
      int         tokens;
      int         kind;
      int         t;
      int         i;
      tokens = $urandom_range(1, 6);
      for (t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            s.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 35) begin
            s.push_back(CharPlus);
         end else if (kind < 57) begin
            s.push_back(CharPct);
            s.push_back(rand_hex());
            s.push_back(rand_hex());
         end else if (kind < 72) begin
            s.push_back(CharPct);
            s.push_back(CharU);
            for (i = 0; i < 4; i++) s.push_back(rand_hex());
         end else if (kind < 78) begin
            s.push_back(CharPct);
            s.push_back(CharPct);
         end else if (kind < 86) begin
            s.push_back(CharPct);
            for (i = $urandom_range(0, 1); i > 0; i--) s.push_back(rand_hex());
            if ($urandom_range(0, 1)) s.push_back(rand_non_hex());
         end else if (kind < 94) begin
            s.push_back(CharPct);
            s.push_back(CharU);
            for (i = $urandom_range(0, 3); i > 0; i--) s.push_back(rand_hex());
            if ($urandom_range(0, 1)) s.push_back(rand_non_hex());
         end else begin
            s.push_back(CharPct);
         end
      end
      for (i = 0; i < s.size(); i++) enc_q.push_back('{s[i], i == s.size() - 1});
   endfunction

   // receiver: changing stall patterns plus one long hold-off
   initial begin : sink_proc
      stall_mode_type mode;
      int             span;
      int             hold_left;
      int             cyc;
      bit             held_off;
      rsp_if.ready = 1'b0;
      mode         = StallNone;
      span         = 0;
      hold_left    = 0;
      cyc          = 0;
      held_off     = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (!held_off && bytes_sent >= HoldAfter) begin
            held_off  = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               span = $urandom_range(20, 80);
            end
            span--;
            case (mode)
               StallNone:  rsp_if.ready <= 1'b1;
               StallLight: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               StallHeavy: rsp_if.ready <= ($urandom_range(0, 9) < 3);
               default:    rsp_if.ready <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   // checker: each response transfer against the oldest expected byte
   always @(posedge clock) begin
      dec_byte_type got;
      dec_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_byte, rsp_if.last_of_run, rsp_if.string_done};
         if (decoded_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
               $display("unexpected byte %h last %b done %b",
                        got.out_byte, got.last_of_run, got.string_done);
         end else begin
            want = decoded_q.pop_front();
            bytes_checked++;
            if (got.string_done) strings_done++;
            if (got !== want) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("mismatch: expected byte %h last %b done %b, got %h %b %b",
                           want.out_byte, want.last_of_run, want.string_done,
                           got.out_byte, got.last_of_run, got.string_done);
            end
         end
      end
   end

   initial begin : main_proc
      enc_byte_type e;
      int           i;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.in_byte       = 8'h00;
      req_if.end_of_string = 1'b0;
      held_cnt             = 0;
      bytes_sent           = 0;
      strings_sent         = 0;
      bytes_checked        = 0;
      strings_done         = 0;
      err_cnt              = 0;
      burst_left           = 0;
      for (i = 0; i < HoldMax; i++) held_bytes[i] = 8'h00;
      dir_tab = '{
         '{"A",      1'b1, 1'b1, "A"},
         '{8'h00,    1'b0, 1'b1, 8'h00},
         '{8'hff,    1'b0, 1'b1, 8'hff},
         '{CharPlus, 1'b1, 1'b1, CharSpace},
         // lone percent cut short by the end of the string
         '{CharPct,  1'b1, 1'b1, CharPct},
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{"f",      1'b0, 1'b0, 8'h00},
         '{"F",      1'b0, 1'b1, 8'hff},
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{CharU,    1'b0, 1'b0, 8'h00},
         '{"0",      1'b0, 1'b0, 8'h00},
         '{"0",      1'b0, 1'b0, 8'h00},
         '{"4",      1'b0, 1'b0, 8'h00},
         '{"2",      1'b0, 1'b1, 8'h42},
         // double percent, then a bad digit after the second one
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{CharPct,  1'b0, 1'b1, CharPct},
         '{"Z",      1'b0, 1'b0, 8'h00},
         // bad digit after the wide escape marker
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{CharU,    1'b0, 1'b0, 8'h00},
         '{"G",      1'b1, 1'b0, 8'h00},
         // wide escape cut short
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{CharU,    1'b0, 1'b0, 8'h00},
         '{"a",      1'b0, 1'b0, 8'h00},
         '{"b",      1'b1, 1'b0, 8'h00},
         // two-digit escape cut short
         '{CharPct,  1'b0, 1'b0, 8'h00},
         '{"4",      1'b1, 1'b0, 8'h00}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DirRows; i++)
         send_byte(dir_tab[i].in_byte, dir_tab[i].end_of_string,
                   dir_tab[i].typed, dir_tab[i].typed_byte);
      while (bytes_sent < DirRows + RandomBytes) begin
         build_string();
         while (enc_q.size() != 0) begin
            e = enc_q.pop_front();
            send_byte(e.in_byte, e.end_of_string, 1'b0, 8'h00);
         end
      end
      // the last byte was just taken: withdraw it before the next edge
      if (req_if.valid) begin
         req_if.valid <= 1'b0;
      end
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d encoded bytes in %0d strings, checked %0d decoded bytes",
               bytes_sent, strings_sent, bytes_checked);
      $display("%0d strings completed, one output hold-off of %0d cycles, %0d mismatches",
               strings_done, HoldCycles, err_cnt);
      if (err_cnt == 0) begin
         $display("tb_url_percent_decoder passed");
      end else begin
         $display("tb_url_percent_decoder failed");
      end
      $finish;
   end

endmodule
